### design/tkc_pkg.sv
package tkc_pkg;

   localparam int KEY_FIELD_W = 48;
   localparam int COUNT_W     = 64;
   localparam int LIMIT_W     = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd30;

   typedef struct packed {
      logic insert;
      logic drain;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

### design/tkc_cell.sv
module tkc_cell #(
   parameter int KEY_W = 48
) (
   input  logic                        clock,
   input  tkc_pkg::cell_cmd_type       cmd,
   input  logic                        valid,
   input  logic [KEY_W-1:0]            new_key,
   input  logic [tkc_pkg::COUNT_W-1:0] new_count,
   input  logic                        prev_stays,
   input  logic [KEY_W-1:0]            prev_key,
   input  logic [tkc_pkg::COUNT_W-1:0] prev_count,
   input  logic [KEY_W-1:0]            next_key,
   input  logic [tkc_pkg::COUNT_W-1:0] next_count,
   output logic                        stays,
   output logic [KEY_W-1:0]            key,
   output logic [tkc_pkg::COUNT_W-1:0] count
);
   import tkc_pkg::*;

   logic [KEY_W-1:0]   key_ff, key_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // sorted prefix: entries that rank at or above the incoming word
   assign stays = valid && (count_ff >= new_count);

   always_comb begin
      key_in   = key_ff;
      count_in = count_ff;
      if (cmd.insert && !stays) begin
         if (prev_stays) begin
            key_in   = new_key;
            count_in = new_count;
         end else begin
            key_in   = prev_key;
            count_in = prev_count;
         end
      end else if (cmd.drain) begin
         key_in   = next_key;
         count_in = next_count;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
   end

   assign key   = key_ff;
   assign count = count_ff;

endmodule

### design/top_k_by_count_selector_unit.sv
// Top-k selector: keeps the keep_limit words with the largest counts in a chain
// of MAX_KEEP sorted cells. A word is taken whenever start is high and busy is
// low; every cell compares against it in parallel and the chain shifts right
// by one past the insertion point. The word marked end_of_set is inserted if it
// ranks in, then the chain drains left through cell 0, one result per cycle
// until all held words are out (busy high), smallest last with rsp_last_of_run.
// Results cannot be stalled. csr_ready is high while not draining.
module top_k_by_count_selector_unit #(
   parameter int MAX_KEEP  = 30,
   parameter int KEY_BYTES = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [tkc_pkg::KEY_FIELD_W-1:0] req_entry_key,
   input  logic [tkc_pkg::COUNT_W-1:0]     req_entry_count,
   input  logic                            req_end_of_set,
   output logic                            rsp_valid,
   output logic [tkc_pkg::KEY_FIELD_W-1:0] rsp_out_key,
   output logic [tkc_pkg::COUNT_W-1:0]     rsp_out_count,
   output logic                            rsp_last_of_run,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tkc_pkg::LIMIT_W-1:0]     csr_keep_limit
);
   import tkc_pkg::*;

   localparam int KEY_W  = (8 * KEY_BYTES < KEY_FIELD_W) ? 8 * KEY_BYTES : KEY_FIELD_W;
   localparam int FILL_W = $clog2(MAX_KEEP + 1);
   localparam int CMP_W  = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;

   state_type state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [KEY_W-1:0]   rsp_key_ff, rsp_key_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [CMP_W-1:0]   limit_ext, eff_limit, fill_ext;
   logic               take, room, any_less, do_insert, do_drain;
   cell_cmd_type       cmd;

   logic [MAX_KEEP-1:0] cell_valid, cell_stays;
   logic [KEY_W-1:0]    cell_key   [MAX_KEEP];
   logic [COUNT_W-1:0]  cell_count [MAX_KEEP];
   logic [KEY_W-1:0]    new_key;

   assign new_key = req_entry_key[KEY_W-1:0];

   assign busy      = (state_ff == ST_DRAIN);
   assign csr_ready = (state_ff == ST_IDLE);
   assign take      = start && !busy;

   always_comb begin
      limit_ext = CMP_W'(limit_ff);
      fill_ext  = CMP_W'(fill_ff);
      if (limit_ext == '0)
         eff_limit = CMP_W'(1);
      else if (limit_ext > CMP_W'(MAX_KEEP))
         eff_limit = CMP_W'(MAX_KEEP);
      else
         eff_limit = limit_ext;
   end

   assign room      = fill_ext < eff_limit;
   assign any_less  = |(cell_valid & ~cell_stays);
   assign do_insert = take && (room || any_less);
   assign do_drain  = (state_ff == ST_DRAIN);

   always_comb begin
      cmd.insert = do_insert;
      cmd.drain  = do_drain;
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_KEEP; gi++) begin : g_cell
         logic               p_stays;
         logic [KEY_W-1:0]   p_key, n_key;
         logic [COUNT_W-1:0] p_count, n_count;

         assign cell_valid[gi] = fill_ff > FILL_W'(gi);

         if (gi == 0) begin : g_first
            assign p_stays = 1'b1;
            assign p_key   = new_key;
            assign p_count = req_entry_count;
         end else begin : g_mid
            assign p_stays = cell_stays[gi-1];
            assign p_key   = cell_key[gi-1];
            assign p_count = cell_count[gi-1];
         end

         if (gi == MAX_KEEP - 1) begin : g_last
            assign n_key   = cell_key[gi];
            assign n_count = cell_count[gi];
         end else begin : g_inner
            assign n_key   = cell_key[gi+1];
            assign n_count = cell_count[gi+1];
         end

         tkc_cell #(
            .KEY_W (KEY_W)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .valid      (cell_valid[gi]),
            .new_key    (new_key),
            .new_count  (req_entry_count),
            .prev_stays (p_stays),
            .prev_key   (p_key),
            .prev_count (p_count),
            .next_key   (n_key),
            .next_count (n_count),
            .stays      (cell_stays[gi]),
            .key        (cell_key[gi]),
            .count      (cell_count[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      limit_in     = limit_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_key_in   = rsp_key_ff;
      rsp_count_in = rsp_count_ff;
      if (csr_valid && csr_ready)
         limit_in = csr_keep_limit;
      case (state_ff)
         ST_IDLE: begin
            if (do_insert && room)
               fill_in = fill_ff + FILL_W'(1);
            if (take && req_end_of_set)
               state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = cell_key[0];
            rsp_count_in = cell_count[0];
            fill_in      = fill_ff - FILL_W'(1);
            if (fill_ff == FILL_W'(1)) begin
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      rsp_key_ff   <= rsp_key_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_out_key     = KEY_FIELD_W'(rsp_key_ff);
   assign rsp_out_count   = rsp_count_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_KEEP))
      else $error("fill level above capacity");

   a_drain_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> rsp_valid)
      else $error("drain cycle gave no word");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run) |-> (fill_ff == '0))
      else $error("last word with entries left");

   a_end_drains: assert property (@(posedge clock) disable iff (reset)
      (take && req_end_of_set) |=> (state_ff == ST_DRAIN && fill_ff != '0))
      else $error("end of set did not start drain");

endmodule
